// ----- hdl/jpt_pkg.sv -----
package jpt_pkg;

    typedef enum logic [3:0] {
        M_START   = 4'd0,
        M_TOP     = 4'd1,
        M_DOT     = 4'd2,
        M_RDOT    = 4'd3,
        M_IDENT   = 4'd4,
        M_BR_OPEN = 4'd5,
        M_INDEX   = 4'd6,
        M_QUOTE   = 4'd7,
        M_ESCAPE  = 4'd8,
        M_CLOSE   = 4'd9,
        M_ERROR   = 4'd10
    } mode_t;

    // event codes
    localparam logic [1:0] EV_KEY  = 2'd0;
    localparam logic [1:0] EV_STEP = 2'd1;
    localparam logic [1:0] EV_END  = 2'd2;

    // step kinds
    localparam logic [2:0] SK_FIELD     = 3'd0;
    localparam logic [2:0] SK_INDEX     = 3'd1;
    localparam logic [2:0] SK_WILD      = 3'd2;
    localparam logic [2:0] SK_REC_FIELD = 3'd3;
    localparam logic [2:0] SK_REC_WILD  = 3'd4;

    // bracket contents
    localparam logic [1:0] BK_WILD  = 2'd0;
    localparam logic [1:0] BK_QUOTE = 2'd1;
    localparam logic [1:0] BK_INDEX = 2'd2;

    // status codes
    localparam logic [3:0] ST_OK           = 4'd0;
    localparam logic [3:0] ST_TRAIL_DOT    = 4'd1;
    localparam logic [3:0] ST_TRAIL_REC    = 4'd2;
    localparam logic [3:0] ST_UNEXPECTED   = 4'd3;
    localparam logic [3:0] ST_EXP_IDENT    = 4'd4;
    localparam logic [3:0] ST_UNTERM_BR    = 4'd5;
    localparam logic [3:0] ST_UNTERM_QUOTE = 4'd6;
    localparam logic [3:0] ST_UNTERM_ESC   = 4'd7;
    localparam logic [3:0] ST_BAD_ESC      = 4'd8;
    localparam logic [3:0] ST_NO_DIGITS    = 4'd9;
    localparam logic [3:0] ST_IDX_OVERFLOW = 4'd10;
    localparam logic [3:0] ST_REC_INDEX    = 4'd11;
    localparam logic [3:0] ST_EXP_CLOSE    = 4'd12;

    // characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LBR    = 8'h5B;
    localparam logic [7:0] CH_RBR    = 8'h5D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;

    localparam int unsigned MAX_RES = 3;

    typedef struct packed {
        mode_t       mode;
        logic        strict;
        logic        rec;
        logic        dq;
        logic [1:0]  bk;
        logic        neg;
        logic [63:0] mag;
        logic        seen;
        logic [3:0]  ferr;
    } state_t;

    localparam state_t STATE_RESET = '{
        mode: M_START, strict: 1'b0, rec: 1'b0, dq: 1'b0, bk: BK_WILD,
        neg: 1'b0, mag: 64'd0, seen: 1'b0, ferr: ST_OK
    };

    typedef struct packed {
        logic [1:0]  event_res;
        logic [2:0]  step_kind;
        logic [7:0]  key_char;
        logic [63:0] index_value;
        logic        dialect;
        logic [3:0]  status;
        logic        last;
    } res_t;

    function automatic logic is_ident(input logic [7:0] c);
        logic r;
        r = 1'b1;
        if (c == CH_DOT || c == CH_LBR || c == CH_RBR || c == CH_SPACE) begin
            r = 1'b0;
        end
        if (c >= CH_TAB && c <= CH_CR) begin
            r = 1'b0;
        end
        return r;
    endfunction

    function automatic res_t mk_res(input logic [1:0] ev, input logic [2:0] kind,
                                    input logic [7:0] key, input logic [63:0] idx,
                                    input logic [3:0] st);
        res_t r;
        r.event_res   = ev;
        r.step_kind   = kind;
        r.key_char    = key;
        r.index_value = idx;
        r.dialect     = 1'b0;
        r.status      = st;
        r.last        = 1'b0;
        return r;
    endfunction

    function automatic logic [3:0] keep_err(input logic [3:0] ferr, input logic [3:0] code);
        return (ferr == ST_OK) ? code : ferr;
    endfunction

endpackage

// ----- hdl/json_path_tokenizer_unit.sv -----
// channel   dir  tdata                                   tuser          tlast
// s_ (path) in   [7:0] ch                                -              final_char
// m_ (res)  out  step_kind,key_char,index_value,         [1:0] event_res last_of_item
//                dialect_out,status (lowest bit first)
//
// One path character is taken per cycle while s_tready is high; its 0..3 results go into a
// 4-deep result queue and leave at one per cycle while m_tready is high.
// s_tready is high while at most one result is queued; it does not depend on m_tready.
// aresetn (synchronous) returns the parser to the start of a path and empties the queue.
// A stalled m_ side holds the head result; input stops once two results are waiting.
module json_path_tokenizer_unit import jpt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,   // final_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [2:0] step_kind, [10:3] key_char, [74:11] index_value,
                                   // [75] dialect_out, [79:76] status
    output logic [1:0]  m_tuser,   // [1:0] event_res
    output logic        m_tlast    // last_of_item
);

    state_t     state_reg;
    state_t     state_next;
    res_t       res [MAX_RES];
    logic [1:0] res_cnt;
    logic       accept;
    logic       room;
    res_t       head;

    assign s_tready = room;
    assign accept   = s_tvalid && s_tready;

    jpt_step u_step (
        .st_i    (state_reg),
        .ch      (s_tdata),
        .fin     (s_tlast),
        .st_o    (state_next),
        .res_o   (res),
        .res_cnt (res_cnt)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    jpt_resq u_resq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_cnt  (res_cnt),
        .push_data (res),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (head)
    );

    assign m_tdata = {head.status, head.dialect, head.index_value, head.key_char,
                      head.step_kind};
    assign m_tuser = head.event_res;
    assign m_tlast = head.last;

endmodule

// ----- hdl/jpt_step.sv -----
module jpt_step import jpt_pkg::*; (
    input  state_t     st_i,
    input  logic [7:0] ch,
    input  logic       fin,
    output state_t     st_o,
    output res_t       res_o [MAX_RES],
    output logic [1:0] res_cnt
);

    state_t      s;
    res_t        r [MAX_RES];
    logic [1:0]  n;
    logic        do_top;
    logic        do_step;
    logic        step_rec;
    logic        do_ident;
    logic        ident_rec;
    logic        do_index;
    logic        do_close;
    logic        over;
    logic [67:0] wide;
    logic [63:0] ival;

    always_comb begin
        s         = st_i;
        n         = 2'd0;
        do_top    = 1'b0;
        do_step   = 1'b0;
        step_rec  = 1'b0;
        do_ident  = 1'b0;
        ident_rec = 1'b0;
        do_index  = 1'b0;
        do_close  = 1'b0;
        over      = 1'b0;
        wide      = 68'd0;
        ival      = 64'd0;
        for (int k = 0; k < MAX_RES; k++) begin
            r[k] = '0;
        end

        case (s.mode)
            M_START: begin
                s.mode = M_TOP;
                if (ch == CH_DOLLAR) begin
                    s.strict = 1'b1;
                end else if (ch != CH_DOT) begin
                    do_top = 1'b1;
                end
            end
            M_TOP: do_top = 1'b1;
            M_DOT: begin
                if (ch == CH_DOT) begin
                    s.mode = M_RDOT;
                end else begin
                    do_step = 1'b1;
                end
            end
            M_RDOT: begin
                do_step  = 1'b1;
                step_rec = 1'b1;
            end
            M_IDENT: begin
                if (is_ident(ch)) begin
                    r[n] = mk_res(EV_KEY, SK_FIELD, ch, 64'd0, ST_OK);
                    n    = n + 2'd1;
                end else begin
                    r[n]   = mk_res(EV_STEP, s.rec ? SK_REC_FIELD : SK_FIELD,
                                    8'd0, 64'd0, ST_OK);
                    n      = n + 2'd1;
                    s.mode = M_TOP;
                    do_top = 1'b1;
                end
            end
            M_BR_OPEN: begin
                if (ch == CH_STAR) begin
                    s.bk   = BK_WILD;
                    s.mode = M_CLOSE;
                end else if (ch == CH_DQUOTE || ch == CH_SQUOTE) begin
                    s.dq   = (ch == CH_DQUOTE);
                    s.bk   = BK_QUOTE;
                    s.mode = M_QUOTE;
                end else begin
                    s.bk   = BK_INDEX;
                    s.neg  = 1'b0;
                    s.mag  = 64'd0;
                    s.seen = 1'b0;
                    s.mode = M_INDEX;
                    if (ch == CH_MINUS || ch == CH_PLUS) begin
                        s.neg = (ch == CH_MINUS);
                    end else begin
                        do_index = 1'b1;
                    end
                end
            end
            M_INDEX: do_index = 1'b1;
            M_QUOTE: begin
                if (ch == (s.dq ? CH_DQUOTE : CH_SQUOTE)) begin
                    s.mode = M_CLOSE;
                end else if (ch == CH_BSLASH) begin
                    s.mode = M_ESCAPE;
                end else begin
                    r[n] = mk_res(EV_KEY, SK_FIELD, ch, 64'd0, ST_OK);
                    n    = n + 2'd1;
                end
            end
            M_ESCAPE: begin
                s.mode = M_QUOTE;
                if (ch == CH_BSLASH || ch == CH_SQUOTE || ch == CH_DQUOTE) begin
                    r[n] = mk_res(EV_KEY, SK_FIELD, ch, 64'd0, ST_OK);
                    n    = n + 2'd1;
                end else if (ch == CH_N) begin
                    r[n] = mk_res(EV_KEY, SK_FIELD, CH_LF, 64'd0, ST_OK);
                    n    = n + 2'd1;
                end else if (ch == CH_R) begin
                    r[n] = mk_res(EV_KEY, SK_FIELD, CH_CR, 64'd0, ST_OK);
                    n    = n + 2'd1;
                end else if (ch == CH_T) begin
                    r[n] = mk_res(EV_KEY, SK_FIELD, CH_TAB, 64'd0, ST_OK);
                    n    = n + 2'd1;
                end else begin
                    s.ferr = keep_err(s.ferr, ST_BAD_ESC);
                    s.mode = M_ERROR;
                end
            end
            M_CLOSE: do_close = 1'b1;
            default: ;
        endcase

        // index digits, saturating x10 accumulate
        if (do_index) begin
            if (ch inside {[CH_0:CH_9]}) begin
                wide   = ({4'd0, s.mag} << 3) + ({4'd0, s.mag} << 1) + {64'd0, ch[3:0]};
                s.mag  = (|wide[67:64]) ? {64{1'b1}} : wide[63:0];
                s.seen = 1'b1;
            end else if (!s.seen) begin
                s.ferr = keep_err(s.ferr, ST_NO_DIGITS);
                s.mode = M_ERROR;
            end else begin
                over = s.neg ? (s.mag > 64'h8000_0000_0000_0000) : s.mag[63];
                if (over) begin
                    s.ferr = keep_err(s.ferr, ST_IDX_OVERFLOW);
                    s.mode = M_ERROR;
                end else if (s.rec) begin
                    s.ferr = keep_err(s.ferr, ST_REC_INDEX);
                    s.mode = M_ERROR;
                end else begin
                    do_close = 1'b1;
                end
            end
        end

        if (do_close) begin
            if (ch != CH_RBR) begin
                s.ferr = keep_err(s.ferr, ST_EXP_CLOSE);
                s.mode = M_ERROR;
            end else begin
                case (s.bk)
                    BK_WILD: r[n] = mk_res(EV_STEP, s.rec ? SK_REC_WILD : SK_WILD,
                                           8'd0, 64'd0, ST_OK);
                    BK_QUOTE: r[n] = mk_res(EV_STEP, s.rec ? SK_REC_FIELD : SK_FIELD,
                                            8'd0, 64'd0, ST_OK);
                    default: begin
                        ival = s.neg ? (64'd0 - s.mag) : s.mag;
                        r[n] = mk_res(EV_STEP, SK_INDEX, 8'd0, ival, ST_OK);
                    end
                endcase
                n      = n + 2'd1;
                s.mode = M_TOP;
            end
        end

        if (do_top) begin
            if (ch == CH_DOT) begin
                s.mode = M_DOT;
            end else if (ch == CH_LBR) begin
                s.rec  = 1'b0;
                s.mode = M_BR_OPEN;
            end else if (!s.strict) begin
                s.mode    = M_TOP;
                do_ident  = 1'b1;
                ident_rec = 1'b0;
            end else begin
                s.ferr = keep_err(s.ferr, ST_UNEXPECTED);
                s.mode = M_ERROR;
            end
        end

        if (do_step) begin
            if (ch == CH_LBR) begin
                s.rec  = step_rec;
                s.mode = M_BR_OPEN;
            end else if (ch == CH_STAR) begin
                r[n]   = mk_res(EV_STEP, step_rec ? SK_REC_WILD : SK_WILD,
                                8'd0, 64'd0, ST_OK);
                n      = n + 2'd1;
                s.mode = M_TOP;
            end else begin
                do_ident  = 1'b1;
                ident_rec = step_rec;
            end
        end

        if (do_ident) begin
            if (is_ident(ch)) begin
                s.rec  = ident_rec;
                r[n]   = mk_res(EV_KEY, SK_FIELD, ch, 64'd0, ST_OK);
                n      = n + 2'd1;
                s.mode = M_IDENT;
            end else begin
                s.ferr = keep_err(s.ferr, ST_EXP_IDENT);
                s.mode = M_ERROR;
            end
        end

        // end of path
        if (fin) begin
            case (s.mode)
                M_DOT:     s.ferr = keep_err(s.ferr, ST_TRAIL_DOT);
                M_RDOT:    s.ferr = keep_err(s.ferr, ST_TRAIL_REC);
                M_IDENT: begin
                    r[n] = mk_res(EV_STEP, s.rec ? SK_REC_FIELD : SK_FIELD,
                                  8'd0, 64'd0, ST_OK);
                    n    = n + 2'd1;
                end
                M_BR_OPEN: s.ferr = keep_err(s.ferr, ST_UNTERM_BR);
                M_INDEX: begin
                    over = s.neg ? (s.mag > 64'h8000_0000_0000_0000) : s.mag[63];
                    if (!s.seen) begin
                        s.ferr = keep_err(s.ferr, ST_NO_DIGITS);
                    end else if (over) begin
                        s.ferr = keep_err(s.ferr, ST_IDX_OVERFLOW);
                    end else if (s.rec) begin
                        s.ferr = keep_err(s.ferr, ST_REC_INDEX);
                    end else begin
                        s.ferr = keep_err(s.ferr, ST_EXP_CLOSE);
                    end
                end
                M_QUOTE:   s.ferr = keep_err(s.ferr, ST_UNTERM_QUOTE);
                M_ESCAPE:  s.ferr = keep_err(s.ferr, ST_UNTERM_ESC);
                M_CLOSE:   s.ferr = keep_err(s.ferr, ST_EXP_CLOSE);
                default: ;
            endcase
            r[n] = mk_res(EV_END, SK_FIELD, 8'd0, 64'd0, s.ferr);
            n    = n + 2'd1;
        end

        for (int k = 0; k < MAX_RES; k++) begin
            r[k].dialect = s.strict;
            r[k].last    = (n != 2'd0) && (2'(k) == n - 2'd1);
        end

        st_o    = fin ? STATE_RESET : s;
        res_cnt = n;
        res_o   = r;
    end

endmodule

// ----- hdl/jpt_resq.sv -----
module jpt_resq import jpt_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  logic [1:0] push_cnt,
    input  res_t       push_data [MAX_RES],
    output logic       room,
    output logic       out_valid,
    input  logic       out_ready,
    output res_t       out_data
);

    res_t       q_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] wr_ptr_next;
    logic [1:0] rd_ptr_reg;
    logic [1:0] rd_ptr_next;
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;
    logic       pop;
    logic [1:0] n_in;

    assign pop       = out_valid && out_ready;
    assign n_in      = push ? push_cnt : 2'd0;
    assign out_valid = (cnt_reg != 3'd0);
    assign out_data  = q_reg[rd_ptr_reg];
    // room for a full burst of results even with nothing leaving
    assign room      = (cnt_reg <= 3'd1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + n_in;
        rd_ptr_next = rd_ptr_reg + (pop ? 2'd1 : 2'd0);
        cnt_next    = cnt_reg + {1'b0, n_in} - (pop ? 3'd1 : 3'd0);
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (2'(k) < n_in) begin
                q_reg[wr_ptr_reg + 2'(k)] <= push_data[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            cnt_reg    <= 3'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule
